// File: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, codes and the crc-8 step for the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
  localparam int unsigned REG_IDX_W = 8;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] CFG_HEADER  = 8'd0;
  localparam logic [REG_IDX_W-1:0] CFG_TRAILER = 8'd1;
  localparam logic [REG_IDX_W-1:0] CFG_START   = 8'd2;
  localparam logic [REG_IDX_W-1:0] CFG_SUCCESS = 8'd3;

  localparam logic [BYTE_W-1:0] START_CMD_RST   = 8'h20;
  localparam logic [BYTE_W-1:0] SUCCESS_CMD_RST = 8'h21;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_START   = 2'd1;
  localparam logic [1:0] EV_SUCCESS = 2'd2;

  // role of a byte as seen by the back end
  typedef enum logic [2:0] {
    TK_CMD  = 3'd0,
    TK_LEN  = 3'd1,
    TK_PAY  = 3'd2,
    TK_CRC  = 3'd3,
    TK_TAIL = 3'd4
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic              first;
    logic [BYTE_W-1:0] data;
  } token_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] trailer_byte;
    logic [BYTE_W-1:0] start_command;
    logic [BYTE_W-1:0] success_command;
  } cfg_t;

  // crc-8/dvb-s2, msb first, one byte
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/sfr_ifs.sv
// ----------------------------------------------------------------------------
// sfr channel interfaces
// received byte, frame result and configuration write channels
// ----------------------------------------------------------------------------
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
  logic       valid;
  logic       ready;
  logic       frame_status;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic [1:0] event_kind;
  logic       event_value;
  modport source (output valid, output frame_status, output command_code,
                  output payload_length, output event_kind, output event_value,
                  input ready);
  modport sink   (input valid, input frame_status, input command_code,
                  input payload_length, input event_kind, input event_value,
                  output ready);
endinterface

interface sfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: sv/serial_frame_receiver_crc8_core.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc8_core
// serial byte frame receiver with crc-8/dvb-s2 payload check
// ----------------------------------------------------------------------------
// takes one received byte per cycle, unless the token queue is full, and deframes
// header, command, length, payload, crc and trailer; one result per good-trailer
// frame gives status, command, length and a start/success event. a byte is
// accepted every cycle while the four-entry token queue has room; the queue only
// fills when the result register is held by a stalled sink. a result reaches the
// output through the token queue, written when its trailer byte is accepted, and
// the result register, loaded when the trailer token leaves the queue.
// the crc is one byte-wide update per cycle in the frame checker while payload
// tokens are popped; configuration writes are taken every cycle.
module serial_frame_receiver_crc8_core (
  input  logic      clk,
  input  logic      rst,
  sfr_rx_if.sink    rx,
  sfr_res_if.source res,
  sfr_cfg_if.sink   cfg
);
  import sfr_pkg::*;

  cfg_t   cfg_regs;
  logic   q_full;
  logic   push;
  token_t push_tok;
  logic   head_valid;
  token_t head_tok;
  logic   tok_pop;

  // configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.header_byte     <= '0;
      cfg_regs.trailer_byte    <= '0;
      cfg_regs.start_command   <= START_CMD_RST;
      cfg_regs.success_command <= SUCCESS_CMD_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        CFG_HEADER:  cfg_regs.header_byte     <= cfg.wr_data;
        CFG_TRAILER: cfg_regs.trailer_byte    <= cfg.wr_data;
        CFG_START:   cfg_regs.start_command   <= cfg.wr_data;
        CFG_SUCCESS: cfg_regs.success_command <= cfg.wr_data;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // front: phase tracking and byte classification
  sfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .cfg      (cfg_regs),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  // decoupling queue
  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (tok_pop)
  );

  // back: crc, event decode, result register
  sfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .tok_valid (head_valid),
    .tok       (head_tok),
    .tok_pop   (tok_pop),
    .res       (res)
  );

endmodule

// File: sv/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// frame parser: tracks the frame phase and tags each byte with its role
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic             clk,
  input  logic             rst,
  sfr_rx_if.sink           rx,
  input  sfr_pkg::cfg_t    cfg,
  input  logic             q_full,
  output logic             push,
  output sfr_pkg::token_t  push_tok
);
  import sfr_pkg::*;

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_CMD     = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRC     = 6'b010000,
    PH_TAIL    = 6'b100000
  } phase_t;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] length, length_next;
  logic [BYTE_W-1:0] count, count_next;
  logic [BYTE_W:0]   count_inc;
  logic              take;

  assign rx.ready  = !q_full;
  assign take      = rx.valid && rx.ready;
  assign count_inc = {1'b0, count} + 1'b1;

  always_comb begin
    phase_next    = phase;
    length_next   = length;
    count_next    = count;
    push          = 1'b0;
    push_tok.kind = TK_CMD;
    push_tok.first = 1'b0;
    push_tok.data = rx.rx_byte;
    if (take) begin
      unique case (phase)
        PH_CMD: begin
          push          = 1'b1;
          push_tok.kind = TK_CMD;
          phase_next    = PH_LEN;
        end
        PH_LEN: begin
          push          = 1'b1;
          push_tok.kind = TK_LEN;
          length_next   = rx.rx_byte;
          count_next    = '0;
          phase_next    = (rx.rx_byte == '0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          push           = 1'b1;
          push_tok.kind  = TK_PAY;
          push_tok.first = (count == '0);
          count_next     = count_inc[BYTE_W-1:0];
          if (count_inc >= {1'b0, length}) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          push          = 1'b1;
          push_tok.kind = TK_CRC;
          phase_next    = PH_TAIL;
        end
        PH_TAIL: begin
          // trailer test first, then header restarts the frame
          if (rx.rx_byte == cfg.trailer_byte) begin
            push          = 1'b1;
            push_tok.kind = TK_TAIL;
            phase_next    = PH_WAIT;
          end else if (rx.rx_byte == cfg.header_byte) begin
            phase_next = PH_CMD;
          end else begin
            phase_next = PH_WAIT;
          end
        end
        default: begin
          phase_next = (rx.rx_byte == cfg.header_byte) ? PH_CMD : PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
    end else begin
      phase <= phase_next;
    end
    length <= length_next;
    count  <= count_next;
  end

endmodule

// File: sv/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// short token queue between parser and frame checker
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfr_pkg::token_t  push_tok,
  output logic             full,
  output logic             head_valid,
  output sfr_pkg::token_t  head_tok,
  input  logic             pop
);
  import sfr_pkg::*;

  token_t              entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                do_push, do_pop;

  assign full       = (fill == QCNT_W'(QDEPTH));
  assign head_valid = (fill != '0);
  assign head_tok   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

endmodule

// File: sv/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// frame checker: crc accumulation, event decode and result register
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic             clk,
  input  logic             rst,
  input  sfr_pkg::cfg_t    cfg,
  input  logic             tok_valid,
  input  sfr_pkg::token_t  tok,
  output logic             tok_pop,
  sfr_res_if.source        res
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] held_command;
  logic [BYTE_W-1:0] held_length;
  logic [BYTE_W-1:0] running_crc;
  logic [BYTE_W-1:0] received_crc;
  logic [BYTE_W-1:0] first_byte;
  logic              res_free;
  logic              good;
  logic [1:0]        kind;
  logic              value;

  assign res_free = !res.valid || res.ready;
  assign tok_pop  = tok_valid && ((tok.kind != TK_TAIL) || res_free);

  always_comb begin
    good  = (running_crc == received_crc);
    kind  = EV_NONE;
    value = 1'b0;
    if (good) begin
      if (held_command == cfg.start_command) begin
        kind = EV_START;
      end else if (held_command == cfg.success_command) begin
        kind = EV_SUCCESS;
      end
      if (kind != EV_NONE) begin
        value = (held_length == '0) || (first_byte != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (tok_pop && (tok.kind == TK_TAIL)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end

    if (tok_pop) begin
      unique case (tok.kind)
        TK_CMD: begin
          held_command <= tok.data;
        end
        TK_LEN: begin
          held_length <= tok.data;
          running_crc <= '0;
        end
        TK_PAY: begin
          running_crc <= crc8_update(running_crc, tok.data);
          if (tok.first) begin
            first_byte <= tok.data;
          end
        end
        TK_CRC: begin
          received_crc <= tok.data;
        end
        TK_TAIL: begin
          res.frame_status   <= !good;
          res.command_code   <= held_command;
          res.payload_length <= held_length;
          res.event_kind     <= kind;
          res.event_value    <= value;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// port-level checks on the frame receiver result channel
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       frame_status,
  input logic [1:0] event_kind,
  input logic       event_value
);
  import sfr_pkg::*;

  // a held transaction keeps its status and event fields
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(frame_status)
      && $stable(event_kind) && $stable(event_value))
    else $error("result transaction changed while stalled");

  // nothing comes out straight after reset
  a_res_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a crc failure never reports an event
  a_fail_no_event: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_status |-> event_kind == EV_NONE && !event_value)
    else $error("event reported on crc failure");

  // event value only accompanies an event, and the kind is a known code
  a_value_needs_event: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (event_kind == EV_NONE && !event_value)
      || event_kind == EV_START || event_kind == EV_SUCCESS)
    else $error("bad event kind or stray event value");

endmodule

bind serial_frame_receiver_crc8_core sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .frame_status (res.frame_status),
  .event_kind   (res.event_kind),
  .event_value  (res.event_value)
);
